### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when cond holds, prop must hold.
`define ASSERT_IMPL(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// Next-cycle implication: when cond holds, prop must hold in the next cycle.
`define ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

### hw/rtl/bsfr_pkg.sv
// ----------------------------------------------------------------------------
// bsfr_pkg
// Types and constants for the byte-stuffed frame receiver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bsfr_pkg;

  localparam int unsigned MIN_FRAME_LEN = 5;
  // decoded count only needs to saturate at MIN_FRAME_LEN
  localparam int unsigned DCNT_W        = $clog2(MIN_FRAME_LEN + 1);

  localparam logic [7:0] ESC_OR_MASK    = 8'h20;

  localparam logic [7:0] DELIM_RESET    = 8'd126;
  localparam logic [7:0] ESC_RESET      = 8'd125;
  localparam logic [7:0] MAX_LEN_RESET  = 8'd254;

  localparam logic [1:0] REG_DELIM      = 2'd0;
  localparam logic [1:0] REG_ESC        = 2'd1;
  localparam logic [1:0] REG_MAX_LEN    = 2'd2;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_NAK      = 2'd1,
    STATUS_RUNT     = 2'd2,
    STATUS_OVERFLOW = 2'd3
  } frame_status_t;

  typedef struct packed {
    logic [7:0] delim;
    logic [7:0] esc;
    logic [7:0] max_len;
  } bsfr_cfg_t;

  typedef struct packed {
    logic [7:0]    data;
    logic          eof;
    frame_status_t status;
  } result_t;

endpackage

### hw/rtl/bsfr_core.sv
// ----------------------------------------------------------------------------
// bsfr_core
// Frame state and per-byte decode; yields at most one result per byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module bsfr_core (
  input  logic                clk,
  input  logic                rst,
  input  bsfr_pkg::bsfr_cfg_t cfg,
  input  logic                step,      // one raw byte transfers this cycle
  input  logic [7:0]          rx_byte,
  output logic                res_valid,
  output bsfr_pkg::result_t   res
);

  logic [7:0]                 raw_count, raw_count_next;
  logic [bsfr_pkg::DCNT_W-1:0] dec_count, dec_count_next;
  logic [7:0]                 running_sum, running_sum_next;
  logic                       esc_pending, esc_pending_next;
  logic [7:0]                 held_byte, held_byte_next;
  logic                       held_valid, held_valid_next;
  logic                       overflowed, overflowed_next;

  logic                       is_delim;
  logic                       have_dec;
  logic [7:0]                 decoded;

  assign is_delim = (rx_byte == cfg.delim);

  always_comb begin
    raw_count_next   = raw_count;
    dec_count_next   = dec_count;
    running_sum_next = running_sum;
    esc_pending_next = esc_pending;
    held_byte_next   = held_byte;
    held_valid_next  = held_valid;
    overflowed_next  = overflowed;
    res_valid        = 1'b0;
    res              = '0;
    have_dec         = 1'b0;
    decoded          = rx_byte;

    if (step) begin
      if (is_delim) begin
        if (overflowed || (raw_count != 8'd0)) begin
          res_valid = 1'b1;
          res.eof   = 1'b1;
          if (overflowed) begin
            res.status = bsfr_pkg::STATUS_OVERFLOW;
          end else if (raw_count < 8'(bsfr_pkg::MIN_FRAME_LEN)) begin
            res.status = bsfr_pkg::STATUS_RUNT;
          end else if (esc_pending || (running_sum != 8'd0) ||
                       (dec_count < bsfr_pkg::DCNT_W'(bsfr_pkg::MIN_FRAME_LEN))) begin
            res.status = bsfr_pkg::STATUS_NAK;
          end else begin
            res.status = bsfr_pkg::STATUS_OK;
          end
        end
        raw_count_next   = 8'd0;
        dec_count_next   = '0;
        running_sum_next = 8'd0;
        esc_pending_next = 1'b0;
        held_byte_next   = 8'd0;
        held_valid_next  = 1'b0;
        overflowed_next  = 1'b0;
      end else if (!overflowed) begin
        if (raw_count >= cfg.max_len) begin
          overflowed_next = 1'b1;
        end else begin
          raw_count_next = raw_count + 8'd1;
          if (esc_pending) begin
            esc_pending_next = 1'b0;
            decoded          = rx_byte | bsfr_pkg::ESC_OR_MASK;
            have_dec         = 1'b1;
          end else if (rx_byte == cfg.esc) begin
            esc_pending_next = 1'b1;
          end else begin
            have_dec = 1'b1;
          end
        end
      end

      if (have_dec) begin
        running_sum_next = running_sum + decoded;
        if (dec_count != bsfr_pkg::DCNT_W'(bsfr_pkg::MIN_FRAME_LEN)) begin
          dec_count_next = dec_count + bsfr_pkg::DCNT_W'(1);
        end
        // previous decoded byte goes out; newest one is held back
        if (held_valid) begin
          res_valid = 1'b1;
          res.data  = held_byte;
        end
        held_byte_next  = decoded;
        held_valid_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      raw_count   <= 8'd0;
      dec_count   <= '0;
      running_sum <= 8'd0;
      esc_pending <= 1'b0;
      held_byte   <= 8'd0;
      held_valid  <= 1'b0;
      overflowed  <= 1'b0;
    end else begin
      raw_count   <= raw_count_next;
      dec_count   <= dec_count_next;
      running_sum <= running_sum_next;
      esc_pending <= esc_pending_next;
      held_byte   <= held_byte_next;
      held_valid  <= held_valid_next;
      overflowed  <= overflowed_next;
    end
  end

  `ASSERT_NEXT(a_delim_clears, step && is_delim,
               raw_count == 8'd0 && !held_valid && !overflowed,
               "frame state not cleared after delimiter")
  `ASSERT_IMPL(a_data_needs_held, res_valid && !res.eof, held_valid,
               "data result without a held byte")
  `ASSERT_IMPL(a_raw_bounded, !overflowed, raw_count <= cfg.max_len || raw_count == 8'd0,
               "raw count passed max length")

endmodule

### hw/rtl/byte_stuffed_frame_receiver_top.sv
// ----------------------------------------------------------------------------
// byte_stuffed_frame_receiver_top
// HDLC-like deframer: unstuffs received bytes, checks an 8-bit additive
// checksum, and streams decoded bytes plus one end-of-frame status.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Signals                         Transfer when
// --------  ---  ------------------------------  ---------------------------
// s_axis    in   tvalid tready tdata[7:0]        tvalid && tready
// m_axis    out  tvalid tready tdata tlast tuser tvalid && tready
// cfg       in   cfg_valid cfg_ready idx data    cfg_valid && cfg_ready
//
// One raw byte per cycle while s_axis_tready is high; a result that a byte yields is registered.
// Throughput set by the single output register: s_axis_tready drops only while
// a result is waiting and m_axis_tready is low.
// Reset (rst, synchronous) clears frame state and restores register defaults.
// The cfg channel is always ready; index 3 is accepted and ignored.
// The last decoded byte of each frame (the checksum) is never sent.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module byte_stuffed_frame_receiver_top (
  input  logic       clk,
  input  logic       rst,
  // raw byte input
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] rx_byte
  // decoded output
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] data_byte
  output logic       m_axis_tlast,   // end_of_frame
  output logic [1:0] m_axis_tuser,   // [1:0] frame_status
  // register writes
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  bsfr_pkg::bsfr_cfg_t cfg;
  bsfr_pkg::result_t   core_res;
  bsfr_pkg::result_t   out_res;
  logic                core_valid;
  logic                s_xfer;
  logic                out_valid;

  // config registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.delim   <= bsfr_pkg::DELIM_RESET;
      cfg.esc     <= bsfr_pkg::ESC_RESET;
      cfg.max_len <= bsfr_pkg::MAX_LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bsfr_pkg::REG_DELIM:   cfg.delim   <= cfg_data;
        bsfr_pkg::REG_ESC:     cfg.esc     <= cfg_data;
        bsfr_pkg::REG_MAX_LEN: cfg.max_len <= cfg_data;
        default: ;
      endcase
    end
  end

  // input side: take a byte whenever the output register is free or draining
  assign s_axis_tready = !out_valid || m_axis_tready;
  assign s_xfer        = s_axis_tvalid && s_axis_tready;

  bsfr_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .step      (s_xfer),
    .rx_byte   (s_axis_tdata),
    .res_valid (core_valid),
    .res       (core_res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s_xfer && core_valid) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_xfer && core_valid) begin
      out_res <= core_res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_res.data;
  assign m_axis_tlast  = out_res.eof;
  assign m_axis_tuser  = 2'(out_res.status);

  `ASSERT_IMPL(a_ready_when_empty, !m_axis_tvalid, s_axis_tready,
               "input stalled with empty output register")
  `ASSERT_IMPL(a_data_status_zero, m_axis_tvalid && !m_axis_tlast, m_axis_tuser == 2'd0,
               "data result carries nonzero status")
  `ASSERT_IMPL(a_end_data_zero, m_axis_tvalid && m_axis_tlast, m_axis_tdata == 8'd0,
               "end result carries nonzero data")

endmodule

### sim/bsfr_checker.sv
// ----------------------------------------------------------------------------
// bsfr_checker
// Watches the raw byte, decoded result and register write channels of the
// frame receiver. Tracks the deframing state itself, keeps the results due
// in order, and compares each result transfer field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bsfr_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  input  logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] rx_byte
  input  logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  input  logic [7:0] m_axis_tdata,   // [7:0] data_byte
  input  logic       m_axis_tlast,   // end_of_frame
  input  logic [1:0] m_axis_tuser,   // [1:0] frame_status
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  output int         fail_count,
  output int         results_due
);

  // register copies
  logic [7:0] delim_reg;
  logic [7:0] esc_reg;
  logic [7:0] max_len_reg;

  // frame state
  logic [7:0] raw_cnt;
  logic [7:0] dec_cnt;       // saturates at MIN_FRAME_LEN
  logic [7:0] sum_acc;
  logic       esc_pend;
  logic [7:0] held_byte;
  logic       held_ok;
  logic       ovf;

  bsfr_pkg::result_t due_results[$];
  int      mismatch_cnt = 0;
  int      due_cnt      = 0;

  assign fail_count  = mismatch_cnt;
  assign results_due = due_cnt;

  function automatic void clear_frame();
    raw_cnt   = '0;
    dec_cnt   = '0;
    sum_acc   = '0;
    esc_pend  = 1'b0;
    held_byte = '0;
    held_ok   = 1'b0;
    ovf       = 1'b0;
  endfunction

  // One raw byte in; returns 1 with res filled when the byte yields a result.
  function automatic bit deframe_byte(input logic [7:0] rx, output bsfr_pkg::result_t res);
    logic [7:0] dec;
    bit         produced;
    produced = 1'b0;
    res      = '0;
    if (rx == delim_reg) begin
      if (ovf || raw_cnt != 0) begin
        // overflow outranks runt, runt outranks the checksum checks
        if (ovf)
          res.status = bsfr_pkg::STATUS_OVERFLOW;
        else if (raw_cnt < bsfr_pkg::MIN_FRAME_LEN)
          res.status = bsfr_pkg::STATUS_RUNT;
        else if (esc_pend || sum_acc != 0 || dec_cnt < bsfr_pkg::MIN_FRAME_LEN)
          res.status = bsfr_pkg::STATUS_NAK;
        else
          res.status = bsfr_pkg::STATUS_OK;
        res.eof  = 1'b1;
        produced = 1'b1;
      end
      clear_frame();
    end else if (!ovf) begin
      if (raw_cnt >= max_len_reg) begin
        ovf = 1'b1;
      end else begin
        raw_cnt = raw_cnt + 8'd1;
        if (esc_pend || rx != esc_reg) begin
          dec      = esc_pend ? (rx | bsfr_pkg::ESC_OR_MASK) : rx;
          esc_pend = 1'b0;
          sum_acc  = sum_acc + dec;
          if (dec_cnt < bsfr_pkg::MIN_FRAME_LEN)
            dec_cnt = dec_cnt + 8'd1;
          // output lags one decoded byte, so the checksum never leaves
          if (held_ok) begin
            res.data = held_byte;
            produced = 1'b1;
          end
          held_byte = dec;
          held_ok   = 1'b1;
        end else begin
          esc_pend = 1'b1;
        end
      end
    end
    return produced;
  endfunction

  always @(posedge clk) begin
    bsfr_pkg::result_t got;
    bsfr_pkg::result_t want;
    bsfr_pkg::result_t nxt;
    if (rst) begin
      delim_reg   = bsfr_pkg::DELIM_RESET;
      esc_reg     = bsfr_pkg::ESC_RESET;
      max_len_reg = bsfr_pkg::MAX_LEN_RESET;
      clear_frame();
      due_results.delete();
    end else begin
      // result side first: a result never stems from the byte taken this edge
      if (m_axis_tvalid && m_axis_tready) begin
        got.data   = m_axis_tdata;
        got.eof    = m_axis_tlast;
        got.status = bsfr_pkg::frame_status_t'(m_axis_tuser);
        if (due_results.size() == 0) begin
          $error("result with none due: data_byte %0h end_of_frame %0b frame_status %0d",
                 got.data, got.eof, got.status);
          mismatch_cnt++;
        end else begin
          want = due_results.pop_front();
          if (got.data !== want.data) begin
            $error("data_byte: expected %0h, got %0h", want.data, got.data);
            mismatch_cnt++;
          end
          if (got.eof !== want.eof) begin
            $error("end_of_frame: expected %0b, got %0b", want.eof, got.eof);
            mismatch_cnt++;
          end
          if (got.status !== want.status) begin
            $error("frame_status: expected %0d, got %0d", want.status, got.status);
            mismatch_cnt++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (deframe_byte(s_axis_tdata, nxt))
          due_results.push_back(nxt);
      end
      // a register write takes effect for bytes after this edge
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          bsfr_pkg::REG_DELIM:   delim_reg   = cfg_data;
          bsfr_pkg::REG_ESC:     esc_reg     = cfg_data;
          bsfr_pkg::REG_MAX_LEN: max_len_reg = cfg_data;
          default: ;
        endcase
      end
    end
    due_cnt = due_results.size();
  end

endmodule

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives raw serial bytes into the frame receiver through several register
// settings and idle patterns; the checker beside the block predicts and
// compares every result, and this module reports the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  localparam int NUM_PHASES    = 6;
  localparam int PHASE_ITEMS   = 225;     // ~1350 raw bytes over all phases
  localparam int HOLD_CYCLES   = 300;     // long receiver hold-off
  localparam int SETTLE_CYCLES = 4;       // registered output, plus margin
  // Slowest run: ~1500 bytes, each at worst a long sender gap plus a long
  // receiver stall, plus the hold-off.
  localparam int CYCLE_LIMIT   = 500000;

  logic       clk           = 1'b0;
  logic       rst           = 1'b1;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata  = '0;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic       m_axis_tlast;
  logic [1:0] m_axis_tuser;
  logic       cfg_valid     = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index     = '0;
  logic [7:0] cfg_data      = '0;

  int fail_count;
  int results_due;

  // stimulus knobs, percent per cycle
  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  bit hold_req     = 1'b0;
  bit hold_done    = 1'b0;

  int sent_cnt  = 0;
  int cycle_cnt = 0;

  // register values in force, needed to build well-formed frames
  logic [7:0] cur_delim = bsfr_pkg::DELIM_RESET;
  logic [7:0] cur_esc   = bsfr_pkg::ESC_RESET;

  logic [7:0] frame_bytes[$];

  always #2 clk = ~clk;

  byte_stuffed_frame_receiver_top i_dut (.*);

  bsfr_checker i_checker (.*);

  // Watchdog: ends a hung run.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Receiver: random stalls per cycle, and a single long hold-off on request
  // so the output register fills and the block backs up its input.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // One raw byte transfer. Drives at a falling edge, returns at the rising
  // edge that completed the transfer; tvalid stays up for a following byte.
  task automatic send_byte(input logic [7:0] b);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sent_cnt++;
  endtask

  task automatic release_input();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic send_frame();
    foreach (frame_bytes[i]) send_byte(frame_bytes[i]);
    frame_bytes.delete();
  endtask

  // Wait for every due result, then let the block settle before a register
  // write; bytes that give no result may still be in flight.
  task automatic drain();
    while (results_due != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic write_regs(input logic [7:0] delim, input logic [7:0] esc,
                            input logic [7:0] max_len);
    write_reg(bsfr_pkg::REG_DELIM, delim);
    write_reg(bsfr_pkg::REG_ESC, esc);
    write_reg(bsfr_pkg::REG_MAX_LEN, max_len);
    @(negedge clk);
    cfg_valid <= 1'b0;
    cur_delim = delim;
    cur_esc   = esc;
  endtask

  // A decoded byte can travel if it is neither delimiter nor escape, or if
  // it can be escaped: needs bit 5 set and a distinct escape byte.
  function automatic bit can_encode(input logic [7:0] d);
    if (d != cur_delim && d != cur_esc)
      return 1'b1;
    return (cur_esc != cur_delim) && d[5];
  endfunction

  // Appends the raw form of one decoded byte. Ordinary bytes with bit 5 set
  // are sometimes escaped too; the escaped raw byte is either form that
  // ORs to the value, which also gives escape-after-escape.
  function automatic void put_decoded(input logic [7:0] d);
    logic [7:0] lo;
    lo = d & ~bsfr_pkg::ESC_OR_MASK;
    if (d == cur_delim || d == cur_esc ||
        (cur_esc != cur_delim && d[5] && $urandom_range(4) == 0)) begin
      frame_bytes.push_back(cur_esc);
      if (lo != cur_delim && (d == cur_delim || $urandom_range(1) == 0))
        frame_bytes.push_back(lo);
      else
        frame_bytes.push_back(d);
    end else begin
      frame_bytes.push_back(d);
    end
  endfunction

  // n payload bytes plus a checksum that zeroes the sum, then the delimiter.
  function automatic void build_good_frame(input int n);
    logic [7:0] sum;
    logic [7:0] d;
    sum = '0;
    for (int i = 0; i < n; i++) begin
      // last payload byte is picked so the checksum is encodable too
      do d = 8'($urandom_range(255));
      while (!can_encode(d) || (i == n - 1 && !can_encode(8'(-(sum + d)))));
      put_decoded(d);
      sum = sum + d;
    end
    if (n == 0) begin
      while (!can_encode(8'(-sum))) begin
        put_decoded(8'h01);
        sum = sum + 8'h01;
      end
    end
    put_decoded(8'(-sum));
    frame_bytes.push_back(cur_delim);
  endfunction

  // Mostly well-formed frames with random content; the rest corrupt,
  // runt, dangling-escape, noise and empty frames.
  task automatic send_random_frame();
    int k;
    int n;
    int idx;
    k = $urandom_range(99);
    if (k < 80 || (k >= 87 && k < 93)) begin
      n = ($urandom_range(29) == 0) ? $urandom_range(240, 270) : $urandom_range(2, 14);
      build_good_frame(n);
      if (k >= 87) begin
        frame_bytes.insert(frame_bytes.size() - 1, cur_esc);
      end else if (k >= 70) begin
        idx = $urandom_range(frame_bytes.size() - 2);
        frame_bytes[idx] = frame_bytes[idx] ^ (8'h01 << $urandom_range(7));
      end
    end else if (k < 97) begin
      n = (k < 87) ? $urandom_range(1, 4) : $urandom_range(0, 10);
      repeat (n) frame_bytes.push_back(8'($urandom_range(255)));
      frame_bytes.push_back(cur_delim);
    end else begin
      frame_bytes.push_back(cur_delim);
    end
    send_frame();
  endtask

  // Directed frames under the reset register values.
  task automatic run_directed();
    // empty frame: no result
    frame_bytes = '{bsfr_pkg::DELIM_RESET};
    send_frame();
    // runt
    frame_bytes = '{8'h01, bsfr_pkg::DELIM_RESET};
    send_frame();
    // escape right before the delimiter
    frame_bytes = '{8'h01, 8'h02, 8'h03, 8'h04, bsfr_pkg::ESC_RESET,
                    bsfr_pkg::DELIM_RESET};
    send_frame();
    // good frame with 00, FF and an escaped delimiter value; checksum 82
    frame_bytes = '{8'h00, 8'hFF, bsfr_pkg::ESC_RESET, 8'h5E, 8'h01, 8'h82,
                    bsfr_pkg::DELIM_RESET};
    send_frame();
    // escape after escape, nonzero sum
    frame_bytes = '{bsfr_pkg::ESC_RESET, bsfr_pkg::ESC_RESET, 8'h10, 8'h20, 8'h30,
                    8'h40, bsfr_pkg::DELIM_RESET};
    send_frame();
    // enough raw bytes but too few decoded ones
    frame_bytes = '{bsfr_pkg::ESC_RESET, 8'h41, bsfr_pkg::ESC_RESET, 8'h42,
                    bsfr_pkg::ESC_RESET, 8'h43, bsfr_pkg::DELIM_RESET};
    send_frame();
  endtask

  initial begin
    int         phase_start;
    logic [7:0] d;
    logic [7:0] e;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      // register setting per phase, extremes included
      case (ph)
        0: write_regs(bsfr_pkg::DELIM_RESET, bsfr_pkg::ESC_RESET, bsfr_pkg::MAX_LEN_RESET);
        1: write_regs(8'h00, 8'hFF, 8'd5);
        2: write_regs(8'hFF, 8'h00, 8'd254);
        3: begin
          d = 8'($urandom_range(255));
          do e = 8'($urandom_range(255)); while (e == d);
          write_regs(d, e, 8'($urandom_range(5, 254)));
        end
        4: begin
          // delimiter and escape share one value
          d = 8'($urandom_range(255));
          write_regs(d, d, 8'd40);
        end
        default: write_regs(bsfr_pkg::DELIM_RESET, bsfr_pkg::ESC_RESET, 8'd30);
      endcase

      // idle pattern: none, sender, receiver, both
      case (ph % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 75; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 75; end
        default: begin tx_idle_pct = 12; rx_stall_pct = 12; end
      endcase

      if (ph == 0) begin
        run_directed();
        // back-pressure: receiver holds off while a long frame streams in
        hold_req = 1'b1;
        build_good_frame(40);
        send_frame();
      end

      phase_start = sent_cnt;
      while (sent_cnt - phase_start < PHASE_ITEMS)
        send_random_frame();
      release_input();
      drain();
    end

    if (fail_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

### byte_stuffed_frame_receiver_top.f
+incdir+hw/rtl
hw/rtl/bsfr_pkg.sv
hw/rtl/bsfr_core.sv
hw/rtl/byte_stuffed_frame_receiver_top.sv
sim/bsfr_checker.sv
sim/tb_top.sv
